FILE: sv/mtk_pkg.sv
// Package of types, constants and the letter pattern table for the Morse text keyer.
package mtk_pkg;

   localparam int CHAR_W  = 8;
   localparam int UNITS_W = 3;
   localparam int TEXT_W  = 7;
   localparam int PAT_W   = 16;
   localparam int IDX_W   = 5;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [UNITS_W-1:0] units_type;
   typedef logic [TEXT_W-1:0]  text_type;
   typedef logic [PAT_W-1:0]   pattern_type;
   typedef logic [IDX_W-1:0]   letter_idx_type;

   localparam units_type UNITS_NONE   = 3'd0;
   localparam units_type UNITS_DOT    = 3'd1;
   localparam units_type UNITS_DASH   = 3'd3;
   localparam units_type UNITS_LETTER = 3'd3;
   localparam units_type UNITS_WORD   = 3'd7;

   localparam text_type TEXT_NONE  = 7'h00;
   localparam text_type TEXT_DOT   = 7'h2E;
   localparam text_type TEXT_DASH  = 7'h2D;
   localparam text_type TEXT_SPACE = 7'h20;
   localparam text_type TEXT_NL    = 7'h0A;

   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHAR_UPPER_Z = 8'h5A;
   localparam char_type CHAR_LOWER_A = 8'h61;
   localparam char_type CHAR_LOWER_Z = 8'h7A;
   localparam char_type CHAR_SPACE   = 8'h20;
   localparam char_type CASE_OFFSET  = 8'h20;

   // Letter patterns, MSB first: one 1-bit is a dot, three 1-bits a dash,
   // a single 0-bit separates elements, and the pattern ends after its last 1-bit.
   function automatic pattern_type letter_pattern(input letter_idx_type idx);
      pattern_type pat;
      unique case (idx)
         5'd0:  pat = 16'hB800;
         5'd1:  pat = 16'hEA80;
         5'd2:  pat = 16'hEBA0;
         5'd3:  pat = 16'hEA00;
         5'd4:  pat = 16'h8000;
         5'd5:  pat = 16'hAE80;
         5'd6:  pat = 16'hEE80;
         5'd7:  pat = 16'hAA00;
         5'd8:  pat = 16'hA000;
         5'd9:  pat = 16'hBBB8;
         5'd10: pat = 16'hEB80;
         5'd11: pat = 16'hBA80;
         5'd12: pat = 16'hEE00;
         5'd13: pat = 16'hE800;
         5'd14: pat = 16'hEEE0;
         5'd15: pat = 16'hBBA0;
         5'd16: pat = 16'hEEB8;
         5'd17: pat = 16'hBA00;
         5'd18: pat = 16'hA800;
         5'd19: pat = 16'hE000;
         5'd20: pat = 16'hAE00;
         5'd21: pat = 16'hAB80;
         5'd22: pat = 16'hBB80;
         5'd23: pat = 16'hEAE0;
         5'd24: pat = 16'hEBB8;
         5'd25: pat = 16'hEEA0;
         default: pat = '0;
      endcase
      return pat;
   endfunction

endpackage

FILE: sv/morse_text_keyer.sv
// Morse text keyer: turns text bytes into timed LED segments and a readback transcript.
//
// The block takes one text byte per input transfer and keys it as international
// Morse code. Each output transfer is one LED segment (lit or dark, with a length
// in dot units), a transcript-only character, or both. Lower-case letters are
// folded to upper case; bytes other than letters and space produce nothing.
// Each letter is followed by a transcript space and, if an earlier letter of the
// message came before it, preceded by a 3-unit dark gap, or by a 7-unit word gap
// carrying three spaces when a space came between the two. A byte flagged as the
// end of the message adds a newline and clears the letter and word-break flags.
// The input side is stalled while a byte is being keyed: the idle state takes a
// byte in, and the keying sequencer then walks its letter pattern through a single
// shifter and issues one output transfer per cycle through the output register
// while the output side does not stall, so a new byte is taken only once the
// previous one is fully keyed.
module morse_text_keyer
   import mtk_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  char_type        req_char_code,
   input  logic            req_end_of_message,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_led_on,
   output units_type       rsp_units,
   output text_type        rsp_text_char,
   output logic            rsp_last_result
);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a byte
   localparam logic [2:0] S_WGAP = 3'd1;  // 7-unit word gap with its first space
   localparam logic [2:0] S_WSP1 = 3'd2;  // second space of the word gap
   localparam logic [2:0] S_WSP2 = 3'd3;  // third space of the word gap
   localparam logic [2:0] S_LGAP = 3'd4;  // 3-unit gap between letters
   localparam logic [2:0] S_ELEM = 3'd5;  // one dot or dash
   localparam logic [2:0] S_EGAP = 3'd6;  // 1-unit gap between elements
   localparam logic [2:0] S_TAIL = 3'd7;  // transcript space after a letter

   logic [2:0]  state_ff, state_in;
   logic        letter_seen_ff, letter_seen_in;
   logic        space_pending_ff, space_pending_in;
   logic        eom_ff, eom_in;
   logic        nl_due_ff, nl_due_in;
   pattern_type pattern_ff, pattern_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        led_ff, led_in;
   units_type   units_ff, units_in;
   text_type    text_ff, text_in;
   logic        last_ff, last_in;

   logic        accept;
   logic        emit_ok;
   logic        emit;
   char_type    folded;
   logic        is_letter;
   logic        is_space;
   char_type    letter_off;
   logic        is_dash;
   pattern_type shifted;

   // A new byte is taken only when the sequencer has finished the previous one.
   // The newline for an end of message is sequenced as the idle state's own
   // output, so the sequencer is busy while it is due.
   assign req_stall = (state_ff != S_IDLE) || nl_due_ff;
   assign accept    = req_valid && !req_stall;

   // The output register can be loaded when empty or when its transfer completes.
   assign emit_ok = !rsp_valid_ff || !rsp_stall;

   // Fold the byte to upper case and classify it.
   always_comb begin
      folded = req_char_code;
      if (req_char_code >= CHAR_LOWER_A && req_char_code <= CHAR_LOWER_Z) begin
         folded = req_char_code - CASE_OFFSET;
      end
      is_letter  = (folded >= CHAR_UPPER_A) && (folded <= CHAR_UPPER_Z);
      is_space   = (folded == CHAR_SPACE);
      letter_off = folded - CHAR_UPPER_A;
   end

   // The shared shifter: a dash is three 1-bits and its separator, a dot one
   // 1-bit and its separator. Whatever is left after the shift is the rest of
   // the letter; an all-zero remainder means the letter is done.
   assign is_dash = (pattern_ff[PAT_W-1 -: 3] == 3'b111);
   assign shifted = is_dash ? (pattern_ff << 4) : (pattern_ff << 2);

   always_comb begin
      state_in         = state_ff;
      letter_seen_in   = letter_seen_ff;
      space_pending_in = space_pending_ff;
      eom_in           = eom_ff;
      nl_due_in        = nl_due_ff;
      pattern_in       = pattern_ff;
      emit             = 1'b0;
      led_in           = 1'b0;
      units_in         = UNITS_NONE;
      text_in          = TEXT_NONE;
      last_in          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (nl_due_ff) begin
               // End of message: transcript-only newline, always the last transfer.
               if (emit_ok) begin
                  emit      = 1'b1;
                  text_in   = TEXT_NL;
                  last_in   = 1'b1;
                  nl_due_in = 1'b0;
               end
            end else if (accept) begin
               eom_in     = req_end_of_message;
               pattern_in = letter_pattern(letter_off[IDX_W-1:0]);
               if (is_letter) begin
                  if (!letter_seen_ff) begin
                     state_in = S_ELEM;
                  end else if (space_pending_ff) begin
                     state_in = S_WGAP;
                  end else begin
                     state_in = S_LGAP;
                  end
                  letter_seen_in   = 1'b1;
                  space_pending_in = 1'b0;
               end else begin
                  if (is_space && letter_seen_ff) begin
                     space_pending_in = 1'b1;
                  end
                  nl_due_in = req_end_of_message;
               end
               if (req_end_of_message) begin
                  letter_seen_in   = 1'b0;
                  space_pending_in = 1'b0;
               end
            end
         end
         S_WGAP: begin
            if (emit_ok) begin
               emit     = 1'b1;
               units_in = UNITS_WORD;
               text_in  = TEXT_SPACE;
               state_in = S_WSP1;
            end
         end
         S_WSP1: begin
            if (emit_ok) begin
               emit     = 1'b1;
               text_in  = TEXT_SPACE;
               state_in = S_WSP2;
            end
         end
         S_WSP2: begin
            if (emit_ok) begin
               emit     = 1'b1;
               text_in  = TEXT_SPACE;
               state_in = S_ELEM;
            end
         end
         S_LGAP: begin
            if (emit_ok) begin
               emit     = 1'b1;
               units_in = UNITS_LETTER;
               state_in = S_ELEM;
            end
         end
         S_ELEM: begin
            if (emit_ok) begin
               emit       = 1'b1;
               led_in     = 1'b1;
               units_in   = is_dash ? UNITS_DASH : UNITS_DOT;
               text_in    = is_dash ? TEXT_DASH : TEXT_DOT;
               pattern_in = shifted;
               state_in   = (shifted != '0) ? S_EGAP : S_TAIL;
            end
         end
         S_EGAP: begin
            if (emit_ok) begin
               emit     = 1'b1;
               units_in = UNITS_DOT;
               state_in = S_ELEM;
            end
         end
         S_TAIL: begin
            if (emit_ok) begin
               emit      = 1'b1;
               text_in   = TEXT_SPACE;
               last_in   = !eom_ff;
               nl_due_in = eom_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The output register holds its transfer until the far side takes it.
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         letter_seen_ff   <= 1'b0;
         space_pending_ff <= 1'b0;
         nl_due_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         letter_seen_ff   <= letter_seen_in;
         space_pending_ff <= space_pending_in;
         nl_due_ff        <= nl_due_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eom_ff     <= eom_in;
      pattern_ff <= pattern_in;
      if (emit) begin
         led_ff   <= led_in;
         units_ff <= units_in;
         text_ff  <= text_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_on      = led_ff;
   assign rsp_units       = units_ff;
   assign rsp_text_char   = text_ff;
   assign rsp_last_result = last_ff;

   // A word break can only be pending once a letter has been keyed.
   assert property (@(posedge clock) disable iff (reset)
      space_pending_ff |-> letter_seen_ff)
      else $error("space pending without a letter seen");

   // Keying an element always has pattern bits left to key.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ELEM) |-> (pattern_ff != '0))
      else $error("element state with an empty pattern");

   // A byte that ends the message leaves both flags clear.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_message) |=> (!letter_seen_ff && !space_pending_ff))
      else $error("flags not cleared at end of message");

   // Loading the final transfer of a byte returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (emit && last_in) |=> (state_ff == S_IDLE && !nl_due_ff))
      else $error("sequencer busy after final transfer");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the Morse text keyer: directed and random text, stalls on both sides.
module testbench
   import mtk_pkg::*;
();

   localparam int QUIET_LIMIT    = 4000;
   localparam int HOLD_OFF_LEN   = 250;
   localparam int TAIL_CYCLES    = 20;
   localparam int PHASE_ITEMS    = 125;
   localparam int REPORT_LIMIT   = 10;

   // One output transfer as the keyer should present it.
   typedef struct packed {
      logic      led_on;
      units_type units;
      text_type  text_char;
      logic      last_result;
   } keyed_segment_type;

   // Predicts the segments that each text byte keys and checks them in order.
   class keying_scoreboard_type;
      keyed_segment_type pending_segments[$];
      bit    letter_seen;
      bit    space_pending;
      string morse_of[26];
      int    mismatches;
      int    bytes_taken;
      int    segments_checked;
      int    letters_keyed;
      int    messages_ended;

      function new();
         morse_of = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                      "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
      endfunction

      function void add_segment(logic led, units_type len, text_type txt);
         keyed_segment_type seg;
         seg = '{led, len, txt, 1'b0};
         pending_segments.push_back(seg);
      endfunction

      // Works out the segments for one accepted byte; returns how many it causes.
      function int note_byte(char_type code, logic eom);
         char_type          upper;
         string             pattern;
         int                start_size;
         keyed_segment_type tail;
         start_size = pending_segments.size();
         bytes_taken++;
         upper = code;
         if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
            upper = code - CASE_OFFSET;
         if (upper >= CHAR_UPPER_A && upper <= CHAR_UPPER_Z) begin
            if (letter_seen) begin
               if (space_pending) begin
                  add_segment(1'b0, UNITS_WORD, TEXT_SPACE);
                  add_segment(1'b0, UNITS_NONE, TEXT_SPACE);
                  add_segment(1'b0, UNITS_NONE, TEXT_SPACE);
               end else begin
                  add_segment(1'b0, UNITS_LETTER, TEXT_NONE);
               end
            end
            pattern = morse_of[upper - CHAR_UPPER_A];
            for (int k = 0; k < pattern.len(); k++) begin
               if (k > 0)
                  add_segment(1'b0, UNITS_DOT, TEXT_NONE);
               if (pattern[k] == ".")
                  add_segment(1'b1, UNITS_DOT, TEXT_DOT);
               else
                  add_segment(1'b1, UNITS_DASH, TEXT_DASH);
            end
            add_segment(1'b0, UNITS_NONE, TEXT_SPACE);
            letter_seen   = 1'b1;
            space_pending = 1'b0;
            letters_keyed++;
         end else if (upper == CHAR_SPACE) begin
            if (letter_seen)
               space_pending = 1'b1;
         end
         if (eom) begin
            add_segment(1'b0, UNITS_NONE, TEXT_NL);
            letter_seen   = 1'b0;
            space_pending = 1'b0;
            messages_ended++;
         end
         if (pending_segments.size() > start_size) begin
            tail = pending_segments.pop_back();
            tail.last_result = 1'b1;
            pending_segments.push_back(tail);
         end
         return pending_segments.size() - start_size;
      endfunction

      // Compares one accepted output transfer with the oldest prediction.
      function void check_segment(logic led, units_type len, text_type txt, logic is_last);
         keyed_segment_type got;
         keyed_segment_type want;
         got = '{led, len, txt, is_last};
         segments_checked++;
         if (pending_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Unexpected output: led %0b units %0d text %02h last %0b",
                        led, len, txt, is_last);
         end else begin
            want = pending_segments.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Output mismatch: expected led %0b units %0d text %02h last %0b, %s",
                           want.led_on, want.units, want.text_char, want.last_result,
                           $sformatf("got led %0b units %0d text %02h last %0b",
                                     led, len, txt, is_last));
            end
         end
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   char_type  req_char_code = '0;
   logic      req_end_of_message = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_led_on;
   units_type rsp_units;
   text_type  rsp_text_char;
   logic      rsp_last_result;

   keying_scoreboard_type keyer_check = new();

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_request   = 0;
   int hold_off_left      = 0;
   int quiet_cycles       = 0;
   int productive_items   = 0;

   morse_text_keyer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_led_on         (rsp_led_on),
      .rsp_units          (rsp_units),
      .rsp_text_char      (rsp_text_char),
      .rsp_last_result    (rsp_last_result)
   );

   always #4 clock = ~clock;

   // Output side: checks each transfer, then decides whether to stall the next cycle.
   // A hold-off request keeps the output stalled for a long stretch so that the
   // keyer backs up and stalls its input while the sender keeps offering bytes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         keyer_check.check_segment(rsp_led_on, rsp_units, rsp_text_char, rsp_last_result);
      if (hold_off_request != 0) begin
         hold_off_left    = HOLD_OFF_LEN;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog: ends the run if neither side completes a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one byte, idling first at the current rate, and returns once it is taken.
   task automatic send_byte(input char_type code, input logic eom);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_char_code      <= code;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (keyer_check.note_byte(code, eom) > 0)
         productive_items++;
   endtask

   // Stops offering bytes until every predicted segment has been seen.
   task automatic drain_output();
      req_valid <= 1'b0;
      while (keyer_check.pending_segments.size() != 0)
         @(posedge clock);
   endtask

   // Short directed sequence: leading, repeated and trailing spaces, skipped bytes
   // around the letter range, a skipped byte that ends a message, a lone
   // lower-case letter, and a word gap before a long letter that ends a message.
   task automatic run_directed();
      char_type codes[23];
      logic     eoms[23];
      codes = '{8'h20, 8'h65, 8'h54, 8'h20, 8'h20, 8'h0A, 8'h4A, 8'hFF, 8'h5A, 8'h20,
                8'h80, 8'h61, 8'h7A, 8'h00, 8'h7F, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h59,
                8'h71, 8'h20, 8'h51};
      eoms  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                1'b0, 1'b0, 1'b1};
      foreach (codes[i])
         send_byte(codes[i], eoms[i]);
   endtask

   // One random message. Most are well formed, ending on their last byte; broken
   // ones end at random points or not at all.
   task automatic send_message(input bit broken);
      int       len;
      int       pick;
      char_type code;
      logic     eom;
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 60)
            code = char_type'(CHAR_UPPER_A + $urandom_range(25)
                              + ($urandom_range(1) ? CASE_OFFSET : 8'd0));
         else if (pick < 80)
            code = CHAR_SPACE;
         else
            code = char_type'($urandom_range(255));
         if (broken)
            eom = ($urandom_range(3) == 0);
         else
            eom = (i == len - 1);
         send_byte(code, eom);
      end
   endtask

   initial begin
      int phase_start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain_output();

      // Four stall mixes: none but an opening long hold-off, sender idle, receiver stalling, and both lightly.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
               hold_off_request   = 1;
            end
            1: begin
               sender_idle_pct    = 55;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 55;
            end
            default: begin
               sender_idle_pct    = 6;
               receiver_stall_pct = 6;
            end
         endcase
         phase_start = keyer_check.bytes_taken;
         while (keyer_check.bytes_taken - phase_start < PHASE_ITEMS)
            send_message($urandom_range(99) < 15);
         drain_output();
      end

      drain_output();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Keyed %0d bytes (%0d with output), %0d letters, %0d message ends.",
               keyer_check.bytes_taken, productive_items, keyer_check.letters_keyed,
               keyer_check.messages_ended);
      $display("Checked %0d output transfers over four stall mixes and a long hold-off.",
               keyer_check.segments_checked);
      if (keyer_check.pending_segments.size() != 0)
         $display("%0d predicted segments never arrived",
                  keyer_check.pending_segments.size());
      if (keyer_check.mismatches == 0 && keyer_check.pending_segments.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches in total", keyer_check.mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/mtk_pkg.sv
sv/morse_text_keyer.sv
test/testbench.sv
